// ===== src/nbtvs_pkg.sv =====
// Package for the tagged binary value size parser.
// Holds item structs, frame and RAM request types, phase codes and constants.
// No dependencies.
package nbtvs_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);

  localparam logic [3:0] TAG_END      = 4'd0;
  localparam logic [3:0] TAG_BYTE     = 4'd1;
  localparam logic [3:0] TAG_BYTES    = 4'd7;
  localparam logic [3:0] TAG_STRING   = 4'd8;
  localparam logic [3:0] TAG_LIST     = 4'd9;
  localparam logic [3:0] TAG_COMPOUND = 4'd10;
  localparam logic [7:0] TAG_MAX      = 8'd10;

  localparam logic [2:0] FIELD_LEN2 = 3'd2;
  localparam logic [2:0] FIELD_LEN4 = 3'd4;

  localparam logic [31:0] SIZE_MAX = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_TAG  = 2'd1,
    ST_TOO_DEEP = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    PH_IDLE, PH_SKIP, PH_LEN2, PH_LEN4, PH_LCOUNT, PH_CTAG,
    PH_NLEN, PH_NAME, PH_VALUE, PH_FIN, PH_LOAD
  } phase_t;

  typedef struct packed {
    logic       cmd;
    logic [3:0] root_type;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] value_size;
    logic [1:0]  status;
  } out_item_t;

  typedef struct packed {
    logic        compound;
    logic [3:0]  etype;
    logic [31:0] left;
  } frame_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    frame_t            wdata;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  // Byte length of the fixed-size types 1..6.
  function automatic logic [31:0] fixed_len(input logic [3:0] t);
    logic [31:0] r;
    case (t)
      4'd1:    r = 32'd1;
      4'd2:    r = 32'd2;
      4'd3:    r = 32'd4;
      4'd4:    r = 32'd8;
      4'd5:    r = 32'd4;
      4'd6:    r = 32'd8;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== src/nbtvs_frame_ram.sv =====
// Frame stack storage: one write port, one registered read port.
// Depends on nbtvs_pkg.
module nbtvs_frame_ram
  import nbtvs_pkg::*;
(
  input  logic     clk,
  input  ram_req_t req,
  output frame_t   rdata
);

  frame_t mem [STACK_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

// ===== src/nbtvs_ctrl.sv =====
// Parse sequencer: byte phases, size count, cached top frame and stack pointer.
// Depends on nbtvs_pkg; drives the frame RAM.
module nbtvs_ctrl
  import nbtvs_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  input  in_item_t  item,
  output logic      item_stall,
  input  logic      out_hold,
  output logic      res_valid,
  output out_item_t res,
  output ram_req_t  ram_req,
  input  frame_t    ram_rdata
);

  phase_t      phase, phase_next;
  logic [2:0]  fbi, fbi_next;
  logic [31:0] acc, acc_next;
  logic [31:0] skip, skip_next;
  logic [31:0] cnt, cnt_next;
  logic [SP_W-1:0] sp, sp_next;
  frame_t      top, top_next;

  logic        accept;
  logic        busy;
  logic        push, pop, fail, done;
  status_t     fcode;
  logic [SP_W-1:0] push_sp;
  frame_t      push_frame;

  logic        bv_go;
  logic [3:0]  bv_t;
  logic [SP_W-1:0] bv_sp;
  logic [7:0]  b;
  logic [31:0] acc_sh;
  logic [2:0]  fbi_inc;
  logic [2:0]  limit;
  logic [SP_W-1:0] sp_m1;
  logic [SP_W-1:0] sp_m2;

  assign busy    = (phase == PH_FIN) || (phase == PH_LOAD);
  assign accept  = item_valid && !item_stall;
  assign b       = item.data_byte;
  assign acc_sh  = {acc[23:0], b};
  assign fbi_inc = fbi + 3'd1;
  assign limit   = ((phase == PH_LEN4) || (phase == PH_LCOUNT)) ? FIELD_LEN4 : FIELD_LEN2;
  assign sp_m1   = sp - SP_W'(1);
  assign sp_m2   = sp - SP_W'(2);

  // Next-state logic.
  always_comb begin
    phase_next = phase;
    fbi_next   = fbi;
    acc_next   = acc;
    skip_next  = skip;
    cnt_next   = cnt;
    sp_next    = sp;
    top_next   = top;
    push       = 1'b0;
    pop        = 1'b0;
    fail       = 1'b0;
    done       = 1'b0;
    fcode      = ST_OK;
    push_sp    = sp;
    push_frame = '0;
    bv_go      = 1'b0;
    bv_t       = TAG_END;
    bv_sp      = sp;

    if (accept) begin
      if (item.cmd) begin
        cnt_next = 32'd1;
        sp_next  = '0;
        bv_go    = 1'b1;
        bv_t     = item.root_type;
        bv_sp    = '0;
      end else if (phase != PH_IDLE) begin
        if (cnt == SIZE_MAX) begin
          fail  = 1'b1;
          fcode = ST_OVERFLOW;
        end else begin
          cnt_next = cnt + 32'd1;
          case (phase)
            PH_SKIP: begin
              skip_next = skip - 32'd1;
              if (skip == 32'd1) phase_next = PH_FIN;
            end
            PH_NAME: begin
              skip_next = skip - 32'd1;
              if (skip == 32'd1) phase_next = PH_VALUE;
            end
            PH_LEN2, PH_LEN4, PH_NLEN, PH_LCOUNT: begin
              acc_next = acc_sh;
              fbi_next = fbi_inc;
              if (fbi_inc >= limit) begin
                if (phase == PH_LCOUNT) begin
                  if (sp == '0) begin
                    fail  = 1'b1;
                    fcode = ST_BAD_TAG;
                  end else if (acc_sh == 32'd0) begin
                    pop = 1'b1;
                  end else begin
                    top_next.left = acc_sh;
                    phase_next    = PH_VALUE;
                  end
                end else if (acc_sh == 32'd0) begin
                  phase_next = (phase == PH_NLEN) ? PH_VALUE : PH_FIN;
                end else begin
                  skip_next  = acc_sh;
                  phase_next = (phase == PH_NLEN) ? PH_NAME : PH_SKIP;
                end
              end
            end
            PH_CTAG: begin
              if (b == 8'd0) begin
                pop = 1'b1;
              end else if (b > TAG_MAX || sp == '0) begin
                fail  = 1'b1;
                fcode = ST_BAD_TAG;
              end else begin
                top_next   = '{compound: 1'b1, etype: b[3:0], left: 32'd0};
                fbi_next   = 3'd0;
                acc_next   = 32'd0;
                phase_next = PH_NLEN;
              end
            end
            PH_VALUE: begin
              bv_go = 1'b1;
              bv_t  = (sp != '0) ? top.etype : TAG_END;
              bv_sp = sp;
            end
            default: phase_next = PH_IDLE;
          endcase
        end
      end
    end

    // Start of a value of type bv_t with the current byte.
    if (bv_go) begin
      if (bv_t >= TAG_BYTE && bv_t < TAG_BYTES) begin
        if (bv_t == TAG_BYTE) begin
          phase_next = PH_FIN;
        end else begin
          skip_next  = fixed_len(bv_t) - 32'd1;
          phase_next = PH_SKIP;
        end
      end else if (bv_t == TAG_BYTES || bv_t == TAG_STRING) begin
        acc_next   = {24'd0, b};
        fbi_next   = 3'd1;
        phase_next = (bv_t == TAG_BYTES) ? PH_LEN4 : PH_LEN2;
      end else if (bv_t == TAG_LIST || bv_t == TAG_COMPOUND) begin
        if (bv_sp == SP_W'(STACK_DEPTH)) begin
          fail  = 1'b1;
          fcode = ST_TOO_DEEP;
        end else if (bv_t == TAG_LIST) begin
          push       = 1'b1;
          push_sp    = bv_sp;
          push_frame = '{compound: 1'b0,
                         etype: (b <= TAG_MAX) ? b[3:0] : TAG_END, left: 32'd0};
          fbi_next   = 3'd0;
          acc_next   = 32'd0;
          phase_next = PH_LCOUNT;
        end else if (b == 8'd0) begin
          // Empty compound: push and pop cancel out.
          phase_next = PH_FIN;
        end else if (b > TAG_MAX) begin
          fail  = 1'b1;
          fcode = ST_BAD_TAG;
        end else begin
          push       = 1'b1;
          push_sp    = bv_sp;
          push_frame = '{compound: 1'b1, etype: b[3:0], left: 32'd0};
          fbi_next   = 3'd0;
          acc_next   = 32'd0;
          phase_next = PH_NLEN;
        end
      end else begin
        fail  = 1'b1;
        fcode = ST_BAD_TAG;
      end
    end

    // Walk up enclosing frames after a value ends.
    if (phase == PH_FIN && !out_hold) begin
      if (sp == '0) begin
        done = 1'b1;
      end else if (top.compound) begin
        phase_next = PH_CTAG;
      end else if (top.left > 32'd1) begin
        top_next.left = top.left - 32'd1;
        phase_next    = PH_VALUE;
      end else begin
        pop = 1'b1;
      end
    end

    if (phase == PH_LOAD) begin
      top_next   = ram_rdata;
      phase_next = PH_FIN;
    end

    if (push) begin
      top_next = push_frame;
      sp_next  = push_sp + SP_W'(1);
    end
    if (pop) begin
      sp_next    = sp_m1;
      phase_next = (sp_m1 != '0) ? PH_LOAD : PH_FIN;
    end
    if (fail || done) begin
      phase_next = PH_IDLE;
      sp_next    = '0;
    end
  end

  // Outputs: handshake, result and RAM request.
  always_comb begin
    item_stall    = busy || out_hold;
    res_valid     = fail || done;
    res           = '0;
    res.status    = fail ? fcode : ST_OK;
    res.value_size = fail ? 32'd0 : cnt;
    ram_req.we    = push && (push_sp != '0);
    ram_req.waddr = ADDR_W'(push_sp - SP_W'(1));
    ram_req.wdata = top;
    ram_req.raddr = sp_m2[ADDR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      fbi   <= '0;
      acc   <= '0;
      skip  <= '0;
      cnt   <= '0;
      sp    <= '0;
    end else begin
      phase <= phase_next;
      fbi   <= fbi_next;
      acc   <= acc_next;
      skip  <= skip_next;
      cnt   <= cnt_next;
      sp    <= sp_next;
    end
    top <= top_next;
  end

endmodule

// ===== src/nbt_value_size_parser.sv =====
// Top level of the tagged binary value size parser.
// Depends on nbtvs_pkg, nbtvs_ctrl and nbtvs_frame_ram.
//
//  channel | handshake                 | payload
//  --------+---------------------------+---------------------------------
//  input   | item_valid / item_stall   | item   (cmd, root_type, data_byte)
//  output  | result_valid / result_stall | result (value_size, status)
//
// Flow: one byte item per cycle while item_stall is low. A value that ends
// walks its enclosing frame; each frame popped whose parent comes from the
// frame RAM passes through a reload phase for the registered read and then
// walks again, while the last frame pops straight to the walk phase.
// Reset: synchronous, clears phase, counters and stack pointer; frames in the
// RAM are never read before written.
// Stalls: item_stall is high while frames are walked and while a result
// waits in the output register under result_stall.
module nbt_value_size_parser
  import nbtvs_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  input  in_item_t  item,
  output logic      item_stall,
  output logic      result_valid,
  output out_item_t result,
  input  logic      result_stall
);

  logic      out_hold;
  logic      res_valid;
  out_item_t res;
  ram_req_t  ram_req;
  frame_t    ram_rdata;

  // Hold the output register while the consumer stalls.
  assign out_hold = result_valid && result_stall;

  nbtvs_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .item_stall (item_stall),
    .out_hold   (out_hold),
    .res_valid  (res_valid),
    .res        (res),
    .ram_req    (ram_req),
    .ram_rdata  (ram_rdata)
  );

  nbtvs_frame_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  // Load a new result, or drop the old one once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_valid) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
    if (res_valid) begin
      result <= res;
    end
  end

endmodule

// ===== src/nbtvs_checker.sv =====
// Port-level checks for the value size parser, bound to the top level.
// Depends on nbtvs_pkg.
module nbtvs_checker
  import nbtvs_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      item_valid,
  input in_item_t  item,
  input logic      item_stall,
  input logic      result_valid,
  input out_item_t result,
  input logic      result_stall
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status != ST_OK |-> result.value_size == 32'd0)
    else $error("error result with nonzero size");

  a_ok_size: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == ST_OK |-> result.value_size != 32'd0)
    else $error("ok result with zero size");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |-> item_stall)
    else $error("input taken while result blocked");

endmodule

bind nbt_value_size_parser nbtvs_checker u_chk (.*);
